/* rtl/ocv_pkg.sv */
// ----------------------------------------------------------------------------
// ocv_pkg
// Shared types and constants for the orbit camera view matrix core.
// ----------------------------------------------------------------------------
`default_nettype none

package ocv_pkg;

  // one camera pose per input transaction
  typedef struct packed {
    logic        [31:0] distance;
    logic        [15:0] pitch_angle;
    logic        [15:0] yaw_angle;
    logic        [15:0] roll_angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } pose_t;

  // one matrix row per output transaction
  typedef struct packed {
    logic        [1:0]  row_index;
    logic signed [47:0] col0;
    logic signed [47:0] col1;
    logic signed [47:0] col2;
    logic signed [47:0] col3;
    logic               last_row;
  } row_t;

  // translation inputs carried alongside the trig pipeline
  typedef struct packed {
    logic        [31:0] distance;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } geom_t;

  // row codes
  localparam logic [1:0] ROW_0    = 2'd0;
  localparam logic [1:0] ROW_1    = 2'd1;
  localparam logic [1:0] ROW_2    = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  // Q1.30 constants
  localparam logic [30:0] ONE30       = 31'h4000_0000;
  localparam logic [30:0] HALF30      = 31'h2000_0000;
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

  // Horner series: divisors and floor(2^32 / divisor)
  localparam int          SER_STEPS = 6;
  localparam logic [7:0]  SER_DIV [SER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] SER_RCP [SER_STEPS] = '{30'd27531841, 30'd39045157, 30'd59652323,
                                                  30'd102261126, 30'd214748364, 30'd715827882};

  // pipeline depths
  localparam int SIN_LAT  = 3 * SER_STEPS + 5;
  localparam int ANG_LAT  = SIN_LAT + 1;
  localparam int ROT_LAT  = 7;
  localparam int PIPE_LAT = ANG_LAT + ROT_LAT;

  // Q1.30 product rounded half up back to Q1.30
  function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
    rnd30 = 32'((p + 64'sd536870912) >>> 30);
  endfunction

endpackage

`default_nettype wire

/* rtl/ocv_sin_lane.sv */
// ----------------------------------------------------------------------------
// ocv_sin_lane
// Pipelined quarter-wave sine: Taylor series in Horner form, three stages
// per series term, reciprocal multiply for each constant division.
// ----------------------------------------------------------------------------
`default_nettype none

module ocv_sin_lane #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ANGLE_BITS-2:0]   arg,
  input  logic                    neg,
  output logic signed [31:0]      value
);

  localparam int QB = ANGLE_BITS - 2;
  localparam int PW = QB + 31;
  localparam int NS = ocv_pkg::SER_STEPS;
  localparam int FD = 3 * NS + 4;
  localparam logic [PW-1:0] HQ = PW'(1) << (QB - 1);

  // flags: {full quarter, negate}
  logic [1:0]    fl [FD];
  logic [PW-1:0] px;
  logic [30:0]   x1;
  logic [61:0]   xsq;
  logic [30:0]   x2s;
  logic [31:0]   sq2;

  // per-term stage registers
  logic [62:0]   pa  [NS];
  logic [31:0]   sqa [NS];
  logic [30:0]   xa  [NS];
  logic [61:0]   mb  [NS];
  logic [31:0]   vb  [NS];
  logic [31:0]   sqb [NS];
  logic [30:0]   xb  [NS];
  logic [30:0]   tc  [NS];
  logic [31:0]   sqc [NS];
  logic [30:0]   xc  [NS];

  logic [61:0]   pf;
  logic [31:0]   s_raw;
  logic [30:0]   s_clip;
  logic signed [31:0] s_sgn;

  // flag shift line
  always_ff @(posedge clk) begin
    if (en) begin
      fl[0] <= {arg[QB], neg};
      for (int i = 1; i < FD; i++) begin
        fl[i] <= fl[i-1];
      end
    end
  end

  // angle to radians, then square
  always_ff @(posedge clk) begin
    if (en) begin
      px  <= PW'(arg[QB-1:0]) * PW'(ocv_pkg::PI_HALF_Q30) + HQ;
      x1  <= px[PW-1:QB];
      xsq <= 62'(px[PW-1:QB]) * 62'(px[PW-1:QB]);
      x2s <= x1;
      sq2 <= 32'((xsq + 62'(ocv_pkg::HALF30)) >> 30);
    end
  end

  // Horner terms: t = 1 - round(x^2 * t) / d
  for (genvar k = 0; k < NS; k++) begin : g_term
    logic [30:0] t_in;
    logic [31:0] sq_in;
    logic [30:0] x_in;
    logic [31:0] v;
    logic [29:0] q0;
    logic [31:0] rem;
    logic [30:0] q;

    if (k == 0) begin : g_first
      assign t_in  = ocv_pkg::ONE30;
      assign sq_in = sq2;
      assign x_in  = x2s;
    end else begin : g_next
      assign t_in  = tc[k-1];
      assign sq_in = sqc[k-1];
      assign x_in  = xc[k-1];
    end

    assign v   = 32'((pa[k] + 63'(ocv_pkg::HALF30)) >> 30);
    assign q0  = mb[k][61:32];
    assign rem = vb[k] - 32'(32'(q0) * 32'(ocv_pkg::SER_DIV[k]));
    assign q   = (rem >= 32'(ocv_pkg::SER_DIV[k])) ? 31'(q0) + 31'd1 : 31'(q0);

    always_ff @(posedge clk) begin
      if (en) begin
        pa[k]  <= 63'(sq_in) * 63'(t_in);
        sqa[k] <= sq_in;
        xa[k]  <= x_in;
        mb[k]  <= 62'(v) * 62'(ocv_pkg::SER_RCP[k]);
        vb[k]  <= v;
        sqb[k] <= sqa[k];
        xb[k]  <= xa[k];
        tc[k]  <= ocv_pkg::ONE30 - q;
        sqc[k] <= sqb[k];
        xc[k]  <= xb[k];
      end
    end
  end

  // final multiply by x, clamp, quadrant sign
  assign s_raw  = 32'((pf + 62'(ocv_pkg::HALF30)) >> 30);
  assign s_clip = (fl[FD-1][1] || (s_raw > 32'(ocv_pkg::ONE30))) ? ocv_pkg::ONE30
                                                                 : s_raw[30:0];
  assign s_sgn  = $signed({1'b0, s_clip});

  always_ff @(posedge clk) begin
    if (en) begin
      pf    <= 62'(xc[NS-1]) * 62'(tc[NS-1]);
      value <= fl[FD-1][0] ? -s_sgn : s_sgn;
    end
  end

endmodule

`default_nettype wire

/* rtl/ocv_angle.sv */
// ----------------------------------------------------------------------------
// ocv_angle
// Sine and cosine of three angles: quadrant folding into six sine lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module ocv_angle #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_BITS-1:0]  ang [3],
  output logic signed [31:0]     sn  [3],
  output logic signed [31:0]     cs  [3]
);

  localparam int QB = ANGLE_BITS - 2;
  localparam logic [QB:0] QTR = {1'b1, {QB{1'b0}}};

  for (genvar g = 0; g < 3; g++) begin : g_ang
    logic [1:0]    quad;
    logic [1:0]    quad_c;
    logic [QB-1:0] rsd;
    logic [QB:0]   sarg;
    logic [QB:0]   carg;
    logic          sneg;
    logic          cneg;

    assign quad   = ang[g][ANGLE_BITS-1:ANGLE_BITS-2];
    assign quad_c = quad + 2'd1;
    assign rsd    = ang[g][QB-1:0];

    // fold into first quadrant; cosine is sine a quarter turn on
    always_ff @(posedge clk) begin
      if (en) begin
        sarg <= quad[0]   ? QTR - {1'b0, rsd} : {1'b0, rsd};
        sneg <= quad[1];
        carg <= quad_c[0] ? QTR - {1'b0, rsd} : {1'b0, rsd};
        cneg <= quad_c[1];
      end
    end

    ocv_sin_lane #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
      .clk(clk), .en(en), .arg(sarg), .neg(sneg), .value(sn[g])
    );

    ocv_sin_lane #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
      .clk(clk), .en(en), .arg(carg), .neg(cneg), .value(cs[g])
    );
  end

endmodule

`default_nettype wire

/* rtl/ocv_rot.sv */
// ----------------------------------------------------------------------------
// ocv_rot
// Composes the Euler rotation and the translation column, seven stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ocv_rot #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  sn [3],
  input  logic signed [31:0]  cs [3],
  input  ocv_pkg::geom_t      geom,
  output logic signed [47:0]  rot_o   [3][3],
  output logic signed [47:0]  trans_o [3]
);

  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [33:0] RH = 34'sd1 <<< (SH - 1);

  logic signed [31:0] sp, cp, sy, cy, sr, cr;

  // stage 0: first products
  logic signed [63:0] p_spsy, p_cpsy, p_cycr, p_cysr, p_cpsr;
  logic signed [63:0] p_cpcr, p_spcy, p_spsr, p_spcr, p_cpcy;
  logic signed [31:0] sr0, cr0, sy0;
  // stage 1: rounded
  logic signed [31:0] spsy1, cpsy1, cycr1, cysr1, cpsr1, cpcr1, spcy1, spsr1, spcr1, cpcy1;
  logic signed [31:0] sr1, cr1, sy1;
  // stage 2: second products
  logic signed [63:0] q_spsycr, q_spsysr, q_cpsycr, q_cpsysr;
  logic signed [31:0] cycr2, cysr2, cpsr2, cpcr2, spcy2, spsr2, spcr2, cpcy2, sy2;
  // stage 3: rotation
  logic signed [32:0] rot3 [3][3];
  // stage 4: translation products and output rounding
  logic signed [65:0] tp [3][3];
  logic signed [47:0] rot4 [3][3];
  // stage 5: sums
  logic signed [67:0] acc [3];
  logic signed [47:0] rot5 [3][3];

  // negated position and distance ride along until used
  logic signed [32:0] np [4][3];
  logic [31:0]        dd [6];

  assign sp = sn[0];
  assign cp = cs[0];
  assign sy = sn[1];
  assign cy = cs[1];
  assign sr = sn[2];
  assign cr = cs[2];

  // side band delay
  always_ff @(posedge clk) begin
    if (en) begin
      np[0][0] <= -33'(geom.pos_x);
      np[0][1] <= -33'(geom.pos_y);
      np[0][2] <= -33'(geom.pos_z);
      dd[0]    <= geom.distance;
      for (int i = 1; i < 4; i++) begin
        np[i] <= np[i-1];
      end
      for (int i = 1; i < 6; i++) begin
        dd[i] <= dd[i-1];
      end
    end
  end

  // stages 0 to 2
  always_ff @(posedge clk) begin
    if (en) begin
      p_spsy <= 64'(sp) * 64'(sy);
      p_cpsy <= 64'(cp) * 64'(sy);
      p_cycr <= 64'(cy) * 64'(cr);
      p_cysr <= 64'(cy) * 64'(sr);
      p_cpsr <= 64'(cp) * 64'(sr);
      p_cpcr <= 64'(cp) * 64'(cr);
      p_spcy <= 64'(sp) * 64'(cy);
      p_spsr <= 64'(sp) * 64'(sr);
      p_spcr <= 64'(sp) * 64'(cr);
      p_cpcy <= 64'(cp) * 64'(cy);
      sr0    <= sr;
      cr0    <= cr;
      sy0    <= sy;

      spsy1 <= ocv_pkg::rnd30(p_spsy);
      cpsy1 <= ocv_pkg::rnd30(p_cpsy);
      cycr1 <= ocv_pkg::rnd30(p_cycr);
      cysr1 <= ocv_pkg::rnd30(p_cysr);
      cpsr1 <= ocv_pkg::rnd30(p_cpsr);
      cpcr1 <= ocv_pkg::rnd30(p_cpcr);
      spcy1 <= ocv_pkg::rnd30(p_spcy);
      spsr1 <= ocv_pkg::rnd30(p_spsr);
      spcr1 <= ocv_pkg::rnd30(p_spcr);
      cpcy1 <= ocv_pkg::rnd30(p_cpcy);
      sr1   <= sr0;
      cr1   <= cr0;
      sy1   <= sy0;

      q_spsycr <= 64'(spsy1) * 64'(cr1);
      q_spsysr <= 64'(spsy1) * 64'(sr1);
      q_cpsycr <= 64'(cpsy1) * 64'(cr1);
      q_cpsysr <= 64'(cpsy1) * 64'(sr1);
      cycr2 <= cycr1;
      cysr2 <= cysr1;
      cpsr2 <= cpsr1;
      cpcr2 <= cpcr1;
      spcy2 <= spcy1;
      spsr2 <= spsr1;
      spcr2 <= spcr1;
      cpcy2 <= cpcy1;
      sy2   <= sy1;
    end
  end

  // stage 3: rotation elements at Q1.30
  always_ff @(posedge clk) begin
    if (en) begin
      rot3[0][0] <= 33'(cycr2);
      rot3[0][1] <= -33'(cysr2);
      rot3[0][2] <= 33'(sy2);
      rot3[1][0] <= 33'(cpsr2) + 33'(ocv_pkg::rnd30(q_spsycr));
      rot3[1][1] <= 33'(cpcr2) - 33'(ocv_pkg::rnd30(q_spsysr));
      rot3[1][2] <= -33'(spcy2);
      rot3[2][0] <= 33'(spsr2) - 33'(ocv_pkg::rnd30(q_cpsycr));
      rot3[2][1] <= 33'(spcr2) + 33'(ocv_pkg::rnd30(q_cpsysr));
      rot3[2][2] <= 33'(cpcy2);
    end
  end

  // stages 4 to 6: translation column, output rounding
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          tp[i][j]   <= 66'(rot3[i][j]) * 66'(np[3][j]);
          rot4[i][j] <= 48'((34'(rot3[i][j]) + RH) >>> SH);
        end
        acc[i] <= 68'(tp[i][0]) + 68'(tp[i][1]) + 68'(tp[i][2]);
      end
      rot5  <= rot4;
      rot_o <= rot5;
      trans_o[0] <= 48'((acc[0] + 68'sd536870912) >>> 30);
      trans_o[1] <= 48'((acc[1] + 68'sd536870912) >>> 30);
      trans_o[2] <= 48'((acc[2] + 68'sd536870912) >>> 30) - $signed({16'd0, dd[5]});
    end
  end

endmodule

`default_nettype wire

/* rtl/ocv_row_ser.sv */
// ----------------------------------------------------------------------------
// ocv_row_ser
// Holds one finished matrix and sends it out one row per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ocv_row_ser #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                mat_valid,
  output logic                load_ok,
  input  logic signed [47:0]  rot_in   [3][3],
  input  logic signed [47:0]  trans_in [3],
  output logic                row_valid,
  input  logic                row_stall,
  output ocv_pkg::row_t       row
);

  localparam logic signed [47:0] ONE_F = 48'sd1 <<< FRAC_BITS;

  logic               busy;
  logic [1:0]         cnt;
  logic signed [47:0] m [3][4];
  logic               take;

  // free, or the last row leaves this cycle
  assign load_ok   = !busy || ((cnt == ocv_pkg::ROW_LAST) && !row_stall);
  assign take      = mat_valid && load_ok;
  assign row_valid = busy;

  // row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= ocv_pkg::ROW_0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= ocv_pkg::ROW_0;
    end else if (busy && !row_stall) begin
      if (cnt == ocv_pkg::ROW_LAST) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  // matrix hold
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m[i][j] <= rot_in[i][j];
        end
        m[i][3] <= trans_in[i];
      end
    end
  end

  // row select
  always_comb begin
    row.row_index = cnt;
    row.last_row  = (cnt == ocv_pkg::ROW_LAST);
    case (cnt)
      ocv_pkg::ROW_0: begin
        row.col0 = m[0][0];
        row.col1 = m[0][1];
        row.col2 = m[0][2];
        row.col3 = m[0][3];
      end
      ocv_pkg::ROW_1: begin
        row.col0 = m[1][0];
        row.col1 = m[1][1];
        row.col2 = m[1][2];
        row.col3 = m[1][3];
      end
      ocv_pkg::ROW_2: begin
        row.col0 = m[2][0];
        row.col1 = m[2][1];
        row.col2 = m[2][2];
        row.col3 = m[2][3];
      end
      default: begin
        row.col0 = '0;
        row.col1 = '0;
        row.col2 = '0;
        row.col3 = ONE_F;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/orbit_camera_view_matrix_core.sv */
// ----------------------------------------------------------------------------
// orbit_camera_view_matrix_core
// Pose accepted to row 0 valid: trig, rotation, row hold stages; rows 1 to 3
// follow on consecutive unstalled cycles. The single row output port sets
// the pose rate: a new matrix loads only as the last row of the one before leaves.
// Reset clears valid bits and the row sender; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module orbit_camera_view_matrix_core #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pose_valid,
  output logic              pose_stall,
  input  ocv_pkg::pose_t    pose,
  output logic              row_valid,
  input  logic              row_stall,
  output ocv_pkg::row_t     row
);

  localparam int AL = ocv_pkg::ANG_LAT;
  localparam int PL = ocv_pkg::PIPE_LAT;

  logic                  en;
  logic                  load_ok;
  logic [PL-1:0]         vld;
  logic [ANGLE_BITS-1:0] ang [3];
  logic signed [31:0]    sn  [3];
  logic signed [31:0]    cs  [3];
  ocv_pkg::geom_t        gd  [AL];
  logic signed [47:0]    rot   [3][3];
  logic signed [47:0]    trans [3];

  // whole pipeline moves together unless the finished matrix cannot leave
  assign en         = !vld[PL-1] || load_ok;
  assign pose_stall = !en;

  assign ang[0] = ANGLE_BITS'(pose.pitch_angle);
  assign ang[1] = ANGLE_BITS'(pose.yaw_angle);
  assign ang[2] = ANGLE_BITS'(pose.roll_angle);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PL-2:0], pose_valid};
    end
  end

  // position and distance wait out the trig pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      gd[0] <= '{distance: pose.distance, pos_x: pose.pos_x,
                 pos_y: pose.pos_y, pos_z: pose.pos_z};
      for (int i = 1; i < AL; i++) begin
        gd[i] <= gd[i-1];
      end
    end
  end

  ocv_angle #(.ANGLE_BITS(ANGLE_BITS)) u_angle (
    .clk(clk), .en(en), .ang(ang), .sn(sn), .cs(cs)
  );

  ocv_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk(clk), .en(en), .sn(sn), .cs(cs), .geom(gd[AL-1]),
    .rot_o(rot), .trans_o(trans)
  );

  ocv_row_ser #(.FRAC_BITS(FRAC_BITS)) u_ser (
    .clk(clk), .rst(rst), .mat_valid(vld[PL-1]), .load_ok(load_ok),
    .rot_in(rot), .trans_in(trans),
    .row_valid(row_valid), .row_stall(row_stall), .row(row)
  );

`ifndef SYNTHESIS
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_stall && !row.last_row |=>
      row_valid && (row.row_index == $past(row.row_index) + 2'd1))
    else $error("row sequence broken");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> (row.last_row == (row.row_index == ocv_pkg::ROW_LAST)))
    else $error("last row mark mismatch");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("valid bits moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    pose_valid && !pose_stall |=> vld[0])
    else $error("accepted transaction lost at entry");
`endif

endmodule

`default_nettype wire
